>>> src/w2r_pkg.sv
`default_nettype none
// Shared types, constants and polynomial coefficients of the lat/lon to national grid transform.
package w2r_pkg;

  // Input request payload
  typedef struct packed {
    logic signed [30:0] latitude_e7;
    logic signed [31:0] longitude_e7;
  } in_t;

  // Result payload
  typedef struct packed {
    logic signed [31:0] grid_x_mm;
    logic signed [31:0] grid_y_mm;
    logic               latitude_outside;
    logic               longitude_outside;
  } out_t;

  // Offsets, powers and cross products in Q40, carried down the pipeline
  typedef struct packed {
    logic signed [47:0] dp1;
    logic signed [47:0] dl1;
    logic signed [47:0] dp2;
    logic signed [47:0] dl2;
    logic signed [47:0] dp1dl1;
    logic signed [47:0] dp3;
    logic signed [47:0] dl3;
    logic signed [47:0] dp2dl1;
    logic signed [47:0] dp1dl2;
    logic signed [47:0] dp2dl2;
    logic signed [47:0] dl4;
    logic signed [47:0] dp1dl3;
    logic signed [47:0] dp2dl3;
    logic signed [47:0] dp3dl1;
    logic signed [47:0] dp1dl4;
  } mono_t;

  // Register stages from input register to output register
  localparam int unsigned NUM_STG = 31;

  // Origin and validity window, 1e-7 degree
  localparam logic signed [32:0] LAT0_E7    = 33'sd521551744;
  localparam logic signed [32:0] LON0_E7    = 33'sd53872062;
  localparam logic signed [31:0] LAT_MIN_E7 = 32'sd505684600;
  localparam logic signed [31:0] LAT_MAX_E7 = 32'sd536270200;
  localparam logic signed [31:0] LON_MIN_E7 = 32'sd29387500;
  localparam logic signed [31:0] LON_MAX_E7 = 32'sd75789300;

  // floor(0.36e-7 * 2^40 * 2^58): offset scale with 58 extra fraction bits
  localparam logic [95:0] OFS_NUM   = 96'd36 << 89;
  localparam logic [95:0] OFS_DIV   = 96'd1953125;
  localparam logic [74:0] OFS_RECIP = 75'(OFS_NUM / OFS_DIV);

  // Coefficient in units of 0.001 to Q20, rounded half away from zero
  function automatic logic signed [47:0] q20(input longint milli);
    logic            neg;
    longint unsigned m;
    longint unsigned v;
    neg = milli < 0;
    if (neg) m = 64'(-milli);
    else     m = 64'(milli);
    v = ((m << 20) + 64'd500) / 64'd1000;
    if (neg) v = -v;
    return 48'(v);
  endfunction

  // X terms: dl1 dl2 dl3 dp1 dp1dl1 dp1dl3 dp2dl1 dp2dl3 dp3dl1
  localparam logic signed [47:0] COEF_X [0:8] = '{
    q20(190094945), q20(-8), q20(-32391), q20(-705), q20(-11832228),
    q20(-608), q20(-114221), q20(148), q20(-2340)
  };

  // Y terms: dl1 dl2 dl4 dp1 dp1dl1 dp1dl2 dp1dl4 dp2 dp2dl2 dp3
  localparam logic signed [47:0] COEF_Y [0:9] = '{
    q20(433), q20(3638893), q20(92), q20(309056544), q20(-32),
    q20(-157984), q20(-54), q20(73077), q20(-6439), q20(59788)
  };

  // False origin in Q20 metres
  localparam logic signed [47:0] CONST_X = q20(155000000);
  localparam logic signed [47:0] CONST_Y = q20(463000000);

endpackage
`default_nettype wire

>>> src/wgs84_to_rd_coordinates.sv
`default_nettype none
// Top level: WGS84 latitude/longitude to national grid X/Y in millimetres.
//
// Converts one lat/lon request per clock with the approximate bivariate polynomial
// around the Amersfoort origin, in fixed point. The datapath is a 31-stage pipeline:
// 5 stages form the Q40 offsets, four chained product levels of 4 stages each build
// the powers and cross products, 4 stages apply the coefficients, and 6 stages sum,
// scale to mm, round and saturate. Throughput is one request per cycle while out_ready
// is high or any stage holds a bubble. Each stage loads when it or any stage after it
// holds a bubble, so a held result stalls only the full run of stages behind it, and
// the input keeps taking requests until all 31 stages are full. Out-of-window flags
// are reported alongside the coordinates, which are computed regardless.
module wgs84_to_rd_coordinates (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  w2r_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output w2r_pkg::out_t   out_data
);

  localparam int unsigned NS = w2r_pkg::NUM_STG;

  logic [NS-1:0] vld_r, vld_nxt, en;

  // stage k may load when any stage from k to the output holds a bubble or out_ready is high
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~(&vld_r[NS-1:k]) | out_ready;
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NS-1];

  // window flags, carried alongside the datapath
  logic signed [31:0] lat_s;
  logic [1:0]         flg_r [0:NS-2];

  assign lat_s = 32'(in_data.latitude_e7);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      flg_r[0] <= {(lat_s < w2r_pkg::LAT_MIN_E7) || (lat_s > w2r_pkg::LAT_MAX_E7),
                   (in_data.longitude_e7 < w2r_pkg::LON_MIN_E7) ||
                   (in_data.longitude_e7 > w2r_pkg::LON_MAX_E7)};
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) flg_r[k] <= flg_r[k-1];
    end
  end

  // scaled offsets, stages 0..4
  logic signed [47:0] dp1_w, dl1_w;

  w2r_offset u_ofs_lat (
    .clk   (clk),
    .en    (en[3:0]),
    .x_i   (33'(in_data.latitude_e7)),
    .org_i (w2r_pkg::LAT0_E7),
    .d_o   (dp1_w)
  );

  w2r_offset u_ofs_lon (
    .clk   (clk),
    .en    (en[3:0]),
    .x_i   (33'(in_data.longitude_e7)),
    .org_i (w2r_pkg::LON0_E7),
    .d_o   (dl1_w)
  );

  // monomial carrier, stages 4..20
  w2r_pkg::mono_t pl_r [4:20];
  w2r_pkg::mono_t pl_nxt [4:20];

  logic signed [47:0] dp2_w, dl2_w, dp1dl1_w;
  logic signed [47:0] dp3_w, dl3_w, dp2dl1_w, dp1dl2_w, dp2dl2_w;
  logic signed [47:0] dl4_w, dp1dl3_w, dp2dl3_w, dp3dl1_w;
  logic signed [47:0] dp1dl4_w;

  // level 1, stages 5..8
  w2r_mul40 u_dp2 (.clk(clk), .en(en[7:5]), .a_i(pl_r[4].dp1), .b_i(pl_r[4].dp1),
                   .p_o(dp2_w));
  w2r_mul40 u_dl2 (.clk(clk), .en(en[7:5]), .a_i(pl_r[4].dl1), .b_i(pl_r[4].dl1),
                   .p_o(dl2_w));
  w2r_mul40 u_dp1dl1 (.clk(clk), .en(en[7:5]), .a_i(pl_r[4].dp1), .b_i(pl_r[4].dl1),
                      .p_o(dp1dl1_w));

  // level 2, stages 9..12
  w2r_mul40 u_dp3 (.clk(clk), .en(en[11:9]), .a_i(pl_r[8].dp2), .b_i(pl_r[8].dp1),
                   .p_o(dp3_w));
  w2r_mul40 u_dl3 (.clk(clk), .en(en[11:9]), .a_i(pl_r[8].dl2), .b_i(pl_r[8].dl1),
                   .p_o(dl3_w));
  w2r_mul40 u_dp2dl1 (.clk(clk), .en(en[11:9]), .a_i(pl_r[8].dp2), .b_i(pl_r[8].dl1),
                      .p_o(dp2dl1_w));
  w2r_mul40 u_dp1dl2 (.clk(clk), .en(en[11:9]), .a_i(pl_r[8].dp1), .b_i(pl_r[8].dl2),
                      .p_o(dp1dl2_w));
  w2r_mul40 u_dp2dl2 (.clk(clk), .en(en[11:9]), .a_i(pl_r[8].dp2), .b_i(pl_r[8].dl2),
                      .p_o(dp2dl2_w));

  // level 3, stages 13..16
  w2r_mul40 u_dl4 (.clk(clk), .en(en[15:13]), .a_i(pl_r[12].dl3), .b_i(pl_r[12].dl1),
                   .p_o(dl4_w));
  w2r_mul40 u_dp1dl3 (.clk(clk), .en(en[15:13]), .a_i(pl_r[12].dp1), .b_i(pl_r[12].dl3),
                      .p_o(dp1dl3_w));
  w2r_mul40 u_dp2dl3 (.clk(clk), .en(en[15:13]), .a_i(pl_r[12].dp2), .b_i(pl_r[12].dl3),
                      .p_o(dp2dl3_w));
  w2r_mul40 u_dp3dl1 (.clk(clk), .en(en[15:13]), .a_i(pl_r[12].dp3), .b_i(pl_r[12].dl1),
                      .p_o(dp3dl1_w));

  // level 4, stages 17..20
  w2r_mul40 u_dp1dl4 (.clk(clk), .en(en[19:17]), .a_i(pl_r[16].dp1), .b_i(pl_r[16].dl4),
                      .p_o(dp1dl4_w));

  always_comb begin
    pl_nxt[4]     = '0;
    pl_nxt[4].dp1 = dp1_w;
    pl_nxt[4].dl1 = dl1_w;
    for (int k = 5; k <= 20; k++) begin
      pl_nxt[k] = pl_r[k-1];
    end
    pl_nxt[8].dp2     = dp2_w;
    pl_nxt[8].dl2     = dl2_w;
    pl_nxt[8].dp1dl1  = dp1dl1_w;
    pl_nxt[12].dp3    = dp3_w;
    pl_nxt[12].dl3    = dl3_w;
    pl_nxt[12].dp2dl1 = dp2dl1_w;
    pl_nxt[12].dp1dl2 = dp1dl2_w;
    pl_nxt[12].dp2dl2 = dp2dl2_w;
    pl_nxt[16].dl4    = dl4_w;
    pl_nxt[16].dp1dl3 = dp1dl3_w;
    pl_nxt[16].dp2dl3 = dp2dl3_w;
    pl_nxt[16].dp3dl1 = dp3dl1_w;
    pl_nxt[20].dp1dl4 = dp1dl4_w;
  end

  always_ff @(posedge clk) begin
    for (int k = 4; k <= 20; k++) begin
      if (en[k]) pl_r[k] <= pl_nxt[k];
    end
  end

  // coefficient terms, stages 21..24
  logic signed [47:0] mono_x [0:8];
  logic signed [47:0] mono_y [0:9];
  logic signed [47:0] tx_w [0:8];
  logic signed [47:0] ty_w [0:9];
  logic signed [47:0] tx_r [0:8];
  logic signed [47:0] ty_r [0:9];

  assign mono_x[0] = pl_r[20].dl1;
  assign mono_x[1] = pl_r[20].dl2;
  assign mono_x[2] = pl_r[20].dl3;
  assign mono_x[3] = pl_r[20].dp1;
  assign mono_x[4] = pl_r[20].dp1dl1;
  assign mono_x[5] = pl_r[20].dp1dl3;
  assign mono_x[6] = pl_r[20].dp2dl1;
  assign mono_x[7] = pl_r[20].dp2dl3;
  assign mono_x[8] = pl_r[20].dp3dl1;

  assign mono_y[0] = pl_r[20].dl1;
  assign mono_y[1] = pl_r[20].dl2;
  assign mono_y[2] = pl_r[20].dl4;
  assign mono_y[3] = pl_r[20].dp1;
  assign mono_y[4] = pl_r[20].dp1dl1;
  assign mono_y[5] = pl_r[20].dp1dl2;
  assign mono_y[6] = pl_r[20].dp1dl4;
  assign mono_y[7] = pl_r[20].dp2;
  assign mono_y[8] = pl_r[20].dp2dl2;
  assign mono_y[9] = pl_r[20].dp3;

  for (genvar i = 0; i < 9; i++) begin : g_tx
    w2r_mul40 u_tx (.clk(clk), .en(en[23:21]), .a_i(w2r_pkg::COEF_X[i]), .b_i(mono_x[i]),
                    .p_o(tx_w[i]));
  end

  for (genvar i = 0; i < 10; i++) begin : g_ty
    w2r_mul40 u_ty (.clk(clk), .en(en[23:21]), .a_i(w2r_pkg::COEF_Y[i]), .b_i(mono_y[i]),
                    .p_o(ty_w[i]));
  end

  // adder tree, stages 25..27
  logic signed [48:0] px_r [0:4];
  logic signed [48:0] py_r [0:4];
  logic signed [50:0] qx_r [0:1];
  logic signed [50:0] qy_r [0:1];
  logic signed [51:0] sx_r, sy_r;

  always_ff @(posedge clk) begin
    if (en[24]) begin
      for (int i = 0; i < 9; i++) tx_r[i] <= tx_w[i];
      for (int i = 0; i < 10; i++) ty_r[i] <= ty_w[i];
    end
    if (en[25]) begin
      for (int j = 0; j < 4; j++) begin
        px_r[j] <= 49'(tx_r[2*j]) + 49'(tx_r[2*j+1]);
      end
      px_r[4] <= 49'(tx_r[8]) + 49'(w2r_pkg::CONST_X);
      for (int j = 0; j < 5; j++) begin
        py_r[j] <= 49'(ty_r[2*j]) + 49'(ty_r[2*j+1]);
      end
    end
    if (en[26]) begin
      qx_r[0] <= 51'(px_r[0]) + 51'(px_r[1]) + 51'(px_r[2]);
      qx_r[1] <= 51'(px_r[3]) + 51'(px_r[4]);
      qy_r[0] <= 51'(py_r[0]) + 51'(py_r[1]) + 51'(py_r[2]);
      qy_r[1] <= 51'(py_r[3]) + 51'(py_r[4]) + 51'(w2r_pkg::CONST_Y);
    end
    if (en[27]) begin
      sx_r <= 52'(qx_r[0]) + 52'(qx_r[1]);
      sy_r <= 52'(qy_r[0]) + 52'(qy_r[1]);
    end
  end

  // Q20 metres to rounded mm, stages 28..30
  logic        nx1_r, ny1_r, nx2_r, ny2_r;
  logic [51:0] mx_r, my_r;
  logic [61:0] scx, scy;
  logic [41:0] mmx_r, mmy_r;
  w2r_pkg::out_t out_r;

  assign scx = mx_r * 62'd1000 + (62'd1 << 19);
  assign scy = my_r * 62'd1000 + (62'd1 << 19);

  function automatic logic signed [31:0] sat_mm(input logic neg, input logic [41:0] mm);
    logic signed [31:0] res;
    if (neg) begin
      res = (mm > 42'd2147483648) ? 32'sh8000_0000 : signed'(32'(-mm));
    end else begin
      res = (mm > 42'd2147483647) ? 32'sh7FFF_FFFF : signed'(mm[31:0]);
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (en[28]) begin
      nx1_r <= sx_r[51];
      ny1_r <= sy_r[51];
      mx_r  <= sx_r[51] ? 52'(-sx_r) : 52'(sx_r);
      my_r  <= sy_r[51] ? 52'(-sy_r) : 52'(sy_r);
    end
    if (en[29]) begin
      nx2_r <= nx1_r;
      ny2_r <= ny1_r;
      mmx_r <= scx[61:20];
      mmy_r <= scy[61:20];
    end
    if (en[30]) begin
      out_r.grid_x_mm         <= sat_mm(nx2_r, mmx_r);
      out_r.grid_y_mm         <= sat_mm(ny2_r, mmy_r);
      out_r.latitude_outside  <= flg_r[NS-2][1];
      out_r.longitude_outside <= flg_r[NS-2][0];
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

>>> src/w2r_mul40.sv
`default_nettype none
// Pipelined Q40 product: round half away from zero, saturate to signed 48 bits.
module w2r_mul40 (
  input  logic               clk,
  input  logic [2:0]         en,
  input  logic signed [47:0] a_i,
  input  logic signed [47:0] b_i,
  output logic signed [47:0] p_o
);

  logic        neg1_r, neg2_r, neg3_r;
  logic [47:0] ua_nxt, ub_nxt, ua_r, ub_r;
  logic [47:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [96:0] sum;
  logic [56:0] mag_r;
  logic        big, over_neg;

  // magnitudes
  assign ua_nxt = a_i[47] ? 48'(-a_i) : 48'(a_i);
  assign ub_nxt = b_i[47] ? 48'(-b_i) : 48'(b_i);

  // four 24x24 partial products, then one rounded sum
  assign sum = {49'd0, pp00_r} + {25'd0, pp01_r, 24'd0} + {25'd0, pp10_r, 24'd0}
             + {1'b0, pp11_r, 48'd0} + (97'd1 << 39);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg1_r <= a_i[47] ^ b_i[47];
      ua_r   <= ua_nxt;
      ub_r   <= ub_nxt;
    end
    if (en[1]) begin
      neg2_r <= neg1_r;
      pp00_r <= ua_r[23:0] * ub_r[23:0];
      pp01_r <= ua_r[23:0] * ub_r[47:24];
      pp10_r <= ua_r[47:24] * ub_r[23:0];
      pp11_r <= ua_r[47:24] * ub_r[47:24];
    end
    if (en[2]) begin
      neg3_r <= neg2_r;
      mag_r  <= sum[96:40];
    end
  end

  // saturate and apply sign
  assign big      = |mag_r[56:47];
  assign over_neg = (|mag_r[56:48]) | (mag_r[47] & (|mag_r[46:0]));

  always_comb begin
    if (neg3_r) begin
      p_o = over_neg ? 48'sh8000_0000_0000 : signed'(48'(-mag_r[47:0]));
    end else begin
      p_o = big ? 48'sh7FFF_FFFF_FFFF : signed'(mag_r[47:0]);
    end
  end

endmodule
`default_nettype wire

>>> src/w2r_offset.sv
`default_nettype none
// Pipelined scaled offset: round(0.36 * (x - origin) * 1e-7) in Q40.
module w2r_offset (
  input  logic               clk,
  input  logic [3:0]         en,
  input  logic signed [32:0] x_i,
  input  logic signed [32:0] org_i,
  output logic signed [47:0] d_o
);

  logic signed [32:0] diff_r;
  logic               neg1_r, neg2_r, neg3_r;
  logic [31:0]        mag_r;
  logic [56:0]        pp0_r, pp1_r, pp2_r;
  logic [106:0]       sum;
  logic [47:0]        v_r;

  // mag * reciprocal with 58 extra fraction bits, rounded at bit 57
  assign sum = {50'd0, pp0_r} + {25'd0, pp1_r, 25'd0} + {pp2_r, 50'd0} + (107'd1 << 57);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      diff_r <= x_i - org_i;
    end
    if (en[1]) begin
      neg1_r <= diff_r[32];
      mag_r  <= diff_r[32] ? 32'(-diff_r) : 32'(diff_r);
    end
    if (en[2]) begin
      neg2_r <= neg1_r;
      pp0_r  <= mag_r * w2r_pkg::OFS_RECIP[24:0];
      pp1_r  <= mag_r * w2r_pkg::OFS_RECIP[49:25];
      pp2_r  <= mag_r * w2r_pkg::OFS_RECIP[74:50];
    end
    if (en[3]) begin
      neg3_r <= neg2_r;
      v_r    <= sum[105:58];
    end
  end

  assign d_o = neg3_r ? signed'(48'(-v_r)) : signed'(v_r);

endmodule
`default_nettype wire
